// ===== rtl/core/md4_hash_engine_unit_macros.svh =====
// Assertion macros shared by the MD4 hash engine RTL.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef MD4_HASH_ENGINE_UNIT_MACROS_SVH
`define MD4_HASH_ENGINE_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MD4HE_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("md4he: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define MD4HE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("md4he: next-cycle check failed");

`endif

// ===== rtl/core/md4he_pkg.sv =====
// Types, constants and step tables of the MD4 hash engine.
// Depends on nothing; used by the buffer, the compression and the top module.
package md4he_pkg;

    typedef logic [31:0] word_t;

    localparam word_t CHAIN_INIT [4] = '{32'h67452301, 32'hefcdab89,
                                         32'h98badcfe, 32'h10325476};
    localparam word_t K_ROUND_G = 32'h5a827999;
    localparam word_t K_ROUND_H = 32'h6ed9eba1;
    localparam logic [7:0] PAD_MARKER = 8'h80;

    localparam logic [5:0] LAST_STEP  = 6'd47;
    localparam logic [6:0] FULL_BLOCK = 7'd64;

    localparam logic [1:0] ROUND_F = 2'd0;
    localparam logic [1:0] ROUND_G = 2'd1;
    localparam logic [1:0] ROUND_H = 2'd2;

    localparam logic [4:0] F_ROT [4] = '{5'd3, 5'd7, 5'd11, 5'd19};
    localparam logic [4:0] G_ROT [4] = '{5'd3, 5'd5, 5'd9, 5'd13};
    localparam logic [4:0] H_ROT [4] = '{5'd3, 5'd9, 5'd11, 5'd15};

    // How the message word is built from the buffer during one compression.
    typedef struct packed {
        logic [6:0]  data_cnt;   // buffer bytes below this position are message
        logic        marker;     // put the pad marker at position data_cnt
        logic        length_on;  // put the bit length into the last eight bytes
        logic [63:0] bit_len;
    } pad_ctl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } cmp_status_t;

    // Message word used by a step: round F in order, round G transposes the
    // 4x4 index grid, round H bit-reverses the index.
    function automatic logic [3:0] msg_index(input logic [5:0] step);
        logic [3:0] i;
        i = step[3:0];
        unique case (step[5:4])
            ROUND_F: return i;
            ROUND_G: return {i[1:0], i[3:2]};
            default: return {i[0], i[1], i[2], i[3]};
        endcase
    endfunction

    function automatic logic [4:0] rot_amount(input logic [5:0] step);
        unique case (step[5:4])
            ROUND_F: return F_ROT[step[1:0]];
            ROUND_G: return G_ROT[step[1:0]];
            default: return H_ROT[step[1:0]];
        endcase
    endfunction

    function automatic word_t round_fn(input logic [1:0] round,
                                       input word_t b, input word_t c, input word_t d);
        unique case (round)
            ROUND_F: return (b & c) | (~b & d);
            ROUND_G: return (b & c) | (b & d) | (c & d);
            default: return b ^ c ^ d;
        endcase
    endfunction

    function automatic word_t round_const(input logic [1:0] round);
        unique case (round)
            ROUND_F: return '0;
            ROUND_G: return K_ROUND_G;
            default: return K_ROUND_H;
        endcase
    endfunction

endpackage

// ===== rtl/core/md4he_if.sv =====
// Valid/ready channel interfaces of the MD4 hash engine: message bytes in,
// digest words out. Depends on nothing.
interface md4he_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       byte_present;
    logic       end_of_message;

    modport source (output valid, output data_byte, output byte_present,
                    output end_of_message, input ready);
    modport sink (input valid, input data_byte, input byte_present,
                  input end_of_message, output ready);
endinterface

interface md4he_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [1:0]  word_number;
    logic        last_word;

    modport source (output valid, output digest_word, output word_number,
                    output last_word, input ready);
    modport sink (input valid, input digest_word, input word_number,
                  input last_word, output ready);
endinterface

// ===== rtl/core/md4he_msg_buf.sv =====
// Block buffer of the MD4 hash engine: 16 x 32-bit memory with byte writes,
// a registered word read and the padding overlay. Depends on md4he_pkg.
module md4he_msg_buf (
    input  logic                 clk,
    input  logic                 wr_en,
    input  logic [5:0]           wr_addr,
    input  logic [7:0]           wr_data,
    input  logic                 rd_en,
    input  logic [3:0]           rd_word,
    input  md4he_pkg::pad_ctl_t  pad,
    output logic [31:0]          x_word
);
    import md4he_pkg::*;

    logic [3:0][7:0] mem [16];
    logic [31:0]     rd_data_reg;
    logic [3:0]      idx_reg;
    logic [3:0][7:0] rd_bytes;
    logic [3:0][7:0] x_bytes;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr[5:2]][wr_addr[1:0]] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_word];
            idx_reg     <= rd_word;
        end
    end

    assign rd_bytes = rd_data_reg;

    // Bytes past the message are never taken from the memory, so stale or
    // unwritten entries do not leak into a padding block.
    always_comb
    begin
        logic [6:0] pos;
        for (int lane = 0; lane < 4; lane++)
        begin
            pos = {1'b0, idx_reg, 2'(lane)};
            if (pos < pad.data_cnt)
            begin
                x_bytes[lane] = rd_bytes[lane];
            end
            else if (pad.marker && (pos == pad.data_cnt))
            begin
                x_bytes[lane] = PAD_MARKER;
            end
            else if (pad.length_on && (pos[5:3] == 3'b111))
            begin
                x_bytes[lane] = pad.bit_len[{pos[2:0], 3'b000} +: 8];
            end
            else
            begin
                x_bytes[lane] = '0;
            end
        end
    end

    assign x_word = x_bytes;

endmodule

// ===== rtl/core/md4he_compress.sv =====
// MD4 compression: one shared step unit run through the 48 steps under a
// small sequencer, plus the four chaining words. Depends on md4he_pkg.
module md4he_compress (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic                    init,
    input  logic [31:0]             x_word,
    output logic                    rd_en,
    output logic [3:0]              rd_word,
    output md4he_pkg::cmp_status_t  status,
    output logic [3:0][31:0]        chain
);
    import md4he_pkg::*;

    typedef enum logic [3:0] {
        C_IDLE = 4'b0001,
        C_LOAD = 4'b0010,
        C_RUN  = 4'b0100,
        C_ADD  = 4'b1000
    } cmp_state_t;

    cmp_state_t       state_reg, state_next;
    logic [5:0]       step_reg, step_next;
    word_t            a_reg, a_next, b_reg, b_next, c_reg, c_next, d_reg, d_next;
    logic [3:0][31:0] chain_reg, chain_next;
    logic             done_reg, done_next;

    word_t       step_sum;
    logic [63:0] rot_wide;
    logic [4:0]  rot_s;
    logic [1:0]  round;

    assign round    = step_reg[5:4];
    assign rot_s    = rot_amount(step_reg);
    assign step_sum = a_reg + round_fn(round, b_reg, c_reg, d_reg) + x_word
                      + round_const(round);
    // The upper half of the doubled word shifted left is the rotation.
    assign rot_wide = {step_sum, step_sum} << rot_s;

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        c_next     = c_reg;
        d_next     = d_reg;
        chain_next = chain_reg;
        done_next  = 1'b0;
        rd_en      = 1'b0;
        rd_word    = msg_index(step_reg + 6'd1);

        unique case (state_reg)
            C_IDLE:
            begin
                if (start)
                begin
                    state_next = C_LOAD;
                end
            end
            C_LOAD:
            begin
                rd_en      = 1'b1;
                rd_word    = msg_index(6'd0);
                a_next     = chain_reg[0];
                b_next     = chain_reg[1];
                c_next     = chain_reg[2];
                d_next     = chain_reg[3];
                step_next  = '0;
                state_next = C_RUN;
            end
            C_RUN:
            begin
                // The word for the next step is fetched while this one runs.
                rd_en     = 1'b1;
                a_next    = d_reg;
                d_next    = c_reg;
                c_next    = b_reg;
                b_next    = rot_wide[63:32];
                step_next = step_reg + 6'd1;
                if (step_reg == LAST_STEP)
                begin
                    state_next = C_ADD;
                end
            end
            C_ADD:
            begin
                chain_next[0] = chain_reg[0] + a_reg;
                chain_next[1] = chain_reg[1] + b_reg;
                chain_next[2] = chain_reg[2] + c_reg;
                chain_next[3] = chain_reg[3] + d_reg;
                done_next     = 1'b1;
                state_next    = C_IDLE;
            end
            default:
            begin
                state_next = C_IDLE;
            end
        endcase

        if (init)
        begin
            for (int w = 0; w < 4; w++)
            begin
                chain_next[w] = CHAIN_INIT[w];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= C_IDLE;
            done_reg  <= 1'b0;
            for (int w = 0; w < 4; w++)
            begin
                chain_reg[w] <= CHAIN_INIT[w];
            end
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            chain_reg <= chain_next;
        end
    end

    always_ff @(posedge clk)
    begin
        step_reg <= step_next;
        a_reg    <= a_next;
        b_reg    <= b_next;
        c_reg    <= c_next;
        d_reg    <= d_next;
    end

    assign status.busy = (state_reg != C_IDLE);
    assign status.done = done_reg;
    assign chain       = chain_reg;

endmodule

// ===== rtl/core/md4_hash_engine_unit.sv =====
// MD4 hash engine.
//
// Input channel msg_in carries one message byte per transaction, with
// byte_present to mark a real byte and end_of_message to close the message.
// Output channel digest_out carries the digest as four transactions, word 0
// first, last_word set on word 3; each word holds four digest bytes, the
// first byte in the low bits.
// A byte that does not complete a 64-byte block and carries no end mark is
// taken and msg_in stays ready. A byte that completes a block holds ready
// low while the shared step unit runs the 48 steps of the compression
// (one step per cycle, plus load, final add and handoff).
// At end of message the padding takes one compression, or two when 56 or
// more bytes are left in the buffer; the four digest words follow, one per
// cycle when the receiver is ready. A stalled receiver holds the current
// word steady and the engine waits; msg_in is not ready until word 3 is
// taken, after which the chaining words, byte count and block count are
// back at their initial values.
// Reset (rst_n, asynchronous, active low) restores the initial chaining
// words and empty counts; the buffer memory needs no clearing.
// Depends on md4he_pkg, md4he_if.sv, md4he_msg_buf and md4he_compress.
`include "md4_hash_engine_unit_macros.svh"

module md4_hash_engine_unit (
    input  logic            clk,
    input  logic            rst_n,
    md4he_in_if.sink        msg_in,
    md4he_out_if.source     digest_out
);
    import md4he_pkg::*;

    typedef enum logic [3:0] {
        T_IDLE  = 4'b0001,
        T_BLOCK = 4'b0010,
        T_PAD   = 4'b0100,
        T_OUT   = 4'b1000
    } top_state_t;

    localparam logic [5:0] LAST_FILL = 6'd63;
    localparam logic [1:0] LAST_WORD = 2'd3;

    top_state_t  state_reg, state_next;
    logic [5:0]  fill_reg, fill_next;
    // The bit length wraps at 64 bits, so only 55 bits of block count matter.
    logic [54:0] count_reg, count_next;
    logic        eom_reg, eom_next;
    logic        two_pass_reg, two_pass_next;
    logic        start_reg, start_next;
    logic [1:0]  word_reg, word_next;
    pad_ctl_t    pad_reg, pad_next;

    logic             accept_in;
    logic             accept_out;
    logic             init_chain;
    logic [6:0]       fill_inc;
    logic [5:0]       pad_n;
    pad_ctl_t         pad_first;
    pad_ctl_t         pad_full;
    logic             rd_en;
    logic [3:0]       rd_word;
    logic [31:0]      x_word;
    cmp_status_t      cstat;
    logic [3:0][31:0] chain;

    assign accept_in  = msg_in.valid && msg_in.ready;
    assign accept_out = digest_out.valid && digest_out.ready;
    assign fill_inc   = {1'b0, fill_reg} + 7'd1;

    // Byte count that the padding starts from: the byte of this transaction
    // is already counted when it arrives together with the end mark.
    assign pad_n = ((state_reg == T_IDLE) && msg_in.byte_present) ? fill_inc[5:0]
                                                                   : fill_reg;

    assign pad_first.data_cnt  = {1'b0, pad_n};
    assign pad_first.marker    = 1'b1;
    assign pad_first.length_on = (pad_n[5:3] != 3'b111);
    assign pad_first.bit_len   = {count_reg, pad_n, 3'b000};

    assign pad_full.data_cnt  = FULL_BLOCK;
    assign pad_full.marker    = 1'b0;
    assign pad_full.length_on = 1'b0;
    assign pad_full.bit_len   = '0;

    always_comb
    begin
        state_next    = state_reg;
        fill_next     = fill_reg;
        count_next    = count_reg;
        eom_next      = eom_reg;
        two_pass_next = two_pass_reg;
        start_next    = 1'b0;
        word_next     = word_reg;
        pad_next      = pad_reg;
        init_chain    = 1'b0;

        unique case (state_reg)
            T_IDLE:
            begin
                if (accept_in)
                begin
                    eom_next = msg_in.end_of_message;
                    if (msg_in.byte_present && (fill_reg == LAST_FILL))
                    begin
                        fill_next  = '0;
                        count_next = count_reg + 55'd1;
                        pad_next   = pad_full;
                        start_next = 1'b1;
                        state_next = T_BLOCK;
                    end
                    else
                    begin
                        if (msg_in.byte_present)
                        begin
                            fill_next = fill_inc[5:0];
                        end
                        if (msg_in.end_of_message)
                        begin
                            pad_next      = pad_first;
                            two_pass_next = !pad_first.length_on;
                            start_next    = 1'b1;
                            state_next    = T_PAD;
                        end
                    end
                end
            end
            T_BLOCK:
            begin
                if (cstat.done)
                begin
                    if (eom_reg)
                    begin
                        pad_next      = pad_first;
                        two_pass_next = !pad_first.length_on;
                        start_next    = 1'b1;
                        state_next    = T_PAD;
                    end
                    else
                    begin
                        state_next = T_IDLE;
                    end
                end
            end
            T_PAD:
            begin
                if (cstat.done)
                begin
                    if (two_pass_reg)
                    begin
                        // Second padding block: zeros and the bit length only.
                        pad_next.data_cnt  = '0;
                        pad_next.marker    = 1'b0;
                        pad_next.length_on = 1'b1;
                        two_pass_next      = 1'b0;
                        start_next         = 1'b1;
                    end
                    else
                    begin
                        word_next  = '0;
                        state_next = T_OUT;
                    end
                end
            end
            T_OUT:
            begin
                if (accept_out)
                begin
                    word_next = word_reg + 2'd1;
                    if (word_reg == LAST_WORD)
                    begin
                        init_chain = 1'b1;
                        fill_next  = '0;
                        count_next = '0;
                        state_next = T_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = T_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= T_IDLE;
            fill_reg     <= '0;
            count_reg    <= '0;
            eom_reg      <= 1'b0;
            two_pass_reg <= 1'b0;
            start_reg    <= 1'b0;
            word_reg     <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            fill_reg     <= fill_next;
            count_reg    <= count_next;
            eom_reg      <= eom_next;
            two_pass_reg <= two_pass_next;
            start_reg    <= start_next;
            word_reg     <= word_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pad_reg <= pad_next;
    end

    md4he_msg_buf u_buf (
        .clk     (clk),
        .wr_en   (accept_in && msg_in.byte_present),
        .wr_addr (fill_reg),
        .wr_data (msg_in.data_byte),
        .rd_en   (rd_en),
        .rd_word (rd_word),
        .pad     (pad_reg),
        .x_word  (x_word)
    );

    md4he_compress u_cmp (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start_reg),
        .init    (init_chain),
        .x_word  (x_word),
        .rd_en   (rd_en),
        .rd_word (rd_word),
        .status  (cstat),
        .chain   (chain)
    );

    assign msg_in.ready           = (state_reg == T_IDLE);
    assign digest_out.valid       = (state_reg == T_OUT);
    assign digest_out.digest_word = chain[word_reg];
    assign digest_out.word_number = word_reg;
    assign digest_out.last_word   = (word_reg == LAST_WORD);

    `MD4HE_ASSERT_IMPLY(a_ready_unit_idle, clk, rst_n, msg_in.ready, !cstat.busy)
    `MD4HE_ASSERT_IMPLY(a_done_when_waiting, clk, rst_n, cstat.done, (state_reg == T_BLOCK) || (state_reg == T_PAD))
    `MD4HE_ASSERT_NEXT(a_start_takes_unit, clk, rst_n, start_reg, cstat.busy)
    `MD4HE_ASSERT_NEXT(a_clean_after_digest, clk, rst_n, accept_out && digest_out.last_word, (fill_reg == 6'd0) && (count_reg == 55'd0) && msg_in.ready)

endmodule
